[sv/rchs_pkg.sv]
// Shared types, constants and helpers for the ray closest-hit unit.
package rchs_pkg;

  localparam int MAX_OBJECTS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int OBJ_IDX_W   = $clog2(MAX_OBJECTS);
  localparam int CNT_W       = OBJ_IDX_W + 1;
  localparam int ACC_W       = 68;
  localparam int UNIT_W      = FRAC_BITS + 2;

  // configuration register indexes
  localparam logic [2:0] CFG_CAM_CX   = 3'd0;
  localparam logic [2:0] CFG_CAM_CY   = 3'd1;
  localparam logic [2:0] CFG_CAM_CZ   = 3'd2;
  localparam logic [2:0] CFG_CAM_DX   = 3'd3;
  localparam logic [2:0] CFG_CAM_DY   = 3'd4;
  localparam logic [2:0] CFG_CAM_DZ   = 3'd5;
  localparam logic [2:0] CFG_FOCAL    = 3'd6;
  localparam logic [2:0] CFG_OBJ_CNT  = 3'd7;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic KIND_SPHERE = 1'b0;

  typedef struct packed {
    logic               mode;
    logic [3:0]         slot;
    logic               kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        radius;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
  } rchs_in_t;

  typedef struct packed {
    logic               hit;
    logic [3:0]         hit_object;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
  } rchs_out_t;

  // table entry; plane normal is stored already normalized
  typedef struct packed {
    logic                     kind;
    logic signed [31:0]       cx;
    logic signed [31:0]       cy;
    logic signed [31:0]       cz;
    logic [30:0]              rad;
    logic signed [UNIT_W-1:0] nx;
    logic signed [UNIT_W-1:0] ny;
    logic signed [UNIT_W-1:0] nz;
  } rchs_rec_t;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 68'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -68'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > SAT_MAX) return 32'sh7fffffff;
    if (v < SAT_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? (~v + 32'd1) : v;
    return r;
  endfunction

endpackage

[sv/ray_closest_hit_sphere_plane_unit.sv]
// Ray closest-hit unit: object table, sequencer, shared multiplier, root and divider.
//
// Command-style block. An input word is taken when start is high and busy is
// low; every word gives exactly one result word on out_word, marked by
// out_strobe for a single cycle, and the receiver cannot stall it. A load word
// normalizes the plane normal and writes one table entry. A cast word
// normalizes the camera normal and the ray, then walks min(object_count, 16)
// entries. All of that work goes to one sequencer driving a single 33x33
// multiplier, a 32-step square-root unit and a 48-step restoring divider.
// The object table is a 16-entry synchronous RAM with a registered read.
// Configuration (cfg_*) is always ready and is to be written only while busy
// is low. A miss or a load returns all zero.
module ray_closest_hit_sphere_plane_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rchs_pkg::rchs_in_t  in_word,
  output logic                out_strobe,
  output rchs_pkg::rchs_out_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import rchs_pkg::*;

  // sequencer states
  localparam logic [5:0] ST_IDLE = 6'd0;
  localparam logic [5:0] ST_UN0  = 6'd1;
  localparam logic [5:0] ST_UN1  = 6'd2;
  localparam logic [5:0] ST_UN2  = 6'd3;
  localparam logic [5:0] ST_UN3  = 6'd4;
  localparam logic [5:0] ST_UNS  = 6'd5;
  localparam logic [5:0] ST_UND  = 6'd6;
  localparam logic [5:0] ST_UNW  = 6'd7;
  localparam logic [5:0] ST_LDWR = 6'd8;
  localparam logic [5:0] ST_CU   = 6'd9;
  localparam logic [5:0] ST_CF0  = 6'd10;
  localparam logic [5:0] ST_CF1  = 6'd11;
  localparam logic [5:0] ST_CF2  = 6'd12;
  localparam logic [5:0] ST_CF3  = 6'd13;
  localparam logic [5:0] ST_CD   = 6'd14;
  localparam logic [5:0] ST_CDU  = 6'd15;
  localparam logic [5:0] ST_OBJ0 = 6'd16;
  localparam logic [5:0] ST_OBJ1 = 6'd17;
  localparam logic [5:0] ST_S0   = 6'd18;
  localparam logic [5:0] ST_S1   = 6'd19;
  localparam logic [5:0] ST_S2   = 6'd20;
  localparam logic [5:0] ST_S3   = 6'd21;
  localparam logic [5:0] ST_S4   = 6'd22;
  localparam logic [5:0] ST_S5   = 6'd23;
  localparam logic [5:0] ST_S6   = 6'd24;
  localparam logic [5:0] ST_S7   = 6'd25;
  localparam logic [5:0] ST_S8   = 6'd26;
  localparam logic [5:0] ST_S9   = 6'd27;
  localparam logic [5:0] ST_P0   = 6'd28;
  localparam logic [5:0] ST_P1   = 6'd29;
  localparam logic [5:0] ST_P2   = 6'd30;
  localparam logic [5:0] ST_P3   = 6'd31;
  localparam logic [5:0] ST_P4   = 6'd32;
  localparam logic [5:0] ST_P5   = 6'd33;
  localparam logic [5:0] ST_P6   = 6'd34;
  localparam logic [5:0] ST_P7   = 6'd35;
  localparam logic [5:0] ST_H0   = 6'd36;
  localparam logic [5:0] ST_H1   = 6'd37;
  localparam logic [5:0] ST_H2   = 6'd38;
  localparam logic [5:0] ST_H3   = 6'd39;
  localparam logic [5:0] ST_H4   = 6'd40;
  localparam logic [5:0] ST_H5   = 6'd41;
  localparam logic [5:0] ST_H6   = 6'd42;
  localparam logic [5:0] ST_H7   = 6'd43;
  localparam logic [5:0] ST_H8   = 6'd44;
  localparam logic [5:0] ST_NEXT = 6'd45;

  localparam logic [63:0] SQ_B_INIT = 64'h4000_0000_0000_0000;
  localparam logic [5:0]  SQ_STEPS  = 6'd32;
  localparam logic [5:0]  DV_STEPS  = 6'd48;
  localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_OBJECTS);

  // ---------------- configuration registers ----------------
  logic signed [31:0] cc_r [3];
  logic signed [31:0] cd_r [3];
  logic [30:0]        focal_r;
  logic [4:0]         ocount_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r[0]  <= '0;
      cc_r[1]  <= '0;
      cc_r[2]  <= '0;
      cd_r[0]  <= '0;
      cd_r[1]  <= '0;
      cd_r[2]  <= 32'sd65536;
      focal_r  <= 31'd65536;
      ocount_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAM_CX:  cc_r[0]  <= cfg_data;
        CFG_CAM_CY:  cc_r[1]  <= cfg_data;
        CFG_CAM_CZ:  cc_r[2]  <= cfg_data;
        CFG_CAM_DX:  cd_r[0]  <= cfg_data;
        CFG_CAM_DY:  cd_r[1]  <= cfg_data;
        CFG_CAM_DZ:  cd_r[2]  <= cfg_data;
        CFG_FOCAL:   focal_r  <= cfg_data[30:0];
        CFG_OBJ_CNT: ocount_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer registers ----------------
  logic [5:0]  state_r, state_nxt;
  logic [5:0]  ret_r, ret_nxt;
  rchs_in_t    in_r, in_nxt;
  logic signed [31:0]       vec_r [3], vec_nxt [3];
  logic signed [UNIT_W-1:0] un_r [3], un_nxt [3];
  logic signed [UNIT_W-1:0] u_r [3], u_nxt [3];
  logic signed [UNIT_W-1:0] duv_r [3], duv_nxt [3];
  logic signed [31:0]       f_r [3], f_nxt [3];
  logic signed [31:0]       l_r [3], l_nxt [3];
  logic signed [31:0]       p_r [3], p_nxt [3];
  logic signed [31:0]       w_r [3], w_nxt [3];
  logic signed [31:0]       bp_r [3], bp_nxt [3];
  logic [1:0]               k_r, k_nxt;
  logic [32:0]              len_r, len_nxt;
  logic signed [31:0]       tca_r, tca_nxt;
  logic signed [31:0]       den_r, den_nxt;
  logic signed [31:0]       num_r, num_nxt;
  logic signed [31:0]       t_r, t_nxt;
  logic signed [31:0]       bt_r, bt_nxt;
  logic signed [ACC_W-1:0]  d2_r, d2_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]         obj_i_r, obj_i_nxt;
  logic [CNT_W-1:0]         n_r, n_nxt;
  logic [OBJ_IDX_W-1:0]     bi_r, bi_nxt;
  logic                     found_r, found_nxt;
  logic                     out_valid_r, out_valid_nxt;
  rchs_out_t                out_r, out_nxt;

  // shared multiplier, product registered
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod_r;
  logic signed [ACC_W-1:0] pfs;

  always_ff @(posedge clk) prod_r <= ma * mb;
  assign pfs = ACC_W'(prod_r >>> FRAC_BITS);

  // ---------------- object table ----------------
  rchs_rec_t mem [MAX_OBJECTS];
  rchs_rec_t rd_q;
  logic      mem_we;
  rchs_rec_t mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[in_r.slot[OBJ_IDX_W-1:0]] <= mem_wdata;
    rd_q <= mem[obj_i_r[OBJ_IDX_W-1:0]];
  end

  // ---------------- square-root unit (two bits a step) ----------------
  logic        sq_start;
  logic [63:0] sq_in;
  logic [63:0] sq_x_r, sq_rt_r, sq_b_r, sq_t;
  logic [5:0]  sq_cnt_r;

  assign sq_t = sq_rt_r + sq_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_cnt_r <= '0;
    end else if (sq_start) begin
      sq_x_r   <= sq_in;
      sq_rt_r  <= '0;
      sq_b_r   <= SQ_B_INIT;
      sq_cnt_r <= SQ_STEPS;
    end else if (sq_cnt_r != 6'd0) begin
      if (sq_x_r >= sq_t) begin
        sq_x_r  <= sq_x_r - sq_t;
        sq_rt_r <= (sq_rt_r >> 1) + sq_b_r;
      end else begin
        sq_rt_r <= sq_rt_r >> 1;
      end
      sq_b_r   <= sq_b_r >> 2;
      sq_cnt_r <= sq_cnt_r - 6'd1;
    end
  end

  // ---------------- restoring divider (one bit a step) ----------------
  logic        dv_start;
  logic [47:0] dv_num;
  logic [32:0] dv_den;
  logic [47:0] dv_n_r, dv_q_r;
  logic [33:0] dv_rem_r, dv_rem2;
  logic [32:0] dv_d_r;
  logic [5:0]  dv_cnt_r;

  assign dv_rem2 = {dv_rem_r[32:0], dv_n_r[47]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_cnt_r <= '0;
    end else if (dv_start) begin
      dv_n_r   <= dv_num;
      dv_d_r   <= dv_den;
      dv_rem_r <= '0;
      dv_q_r   <= '0;
      dv_cnt_r <= DV_STEPS;
    end else if (dv_cnt_r != 6'd0) begin
      dv_n_r <= dv_n_r << 1;
      if (dv_rem2 >= {1'b0, dv_d_r}) begin
        dv_rem_r <= dv_rem2 - {1'b0, dv_d_r};
        dv_q_r   <= {dv_q_r[46:0], 1'b1};
      end else begin
        dv_rem_r <= dv_rem2;
        dv_q_r   <= {dv_q_r[46:0], 1'b0};
      end
      dv_cnt_r <= dv_cnt_r - 6'd1;
    end
  end

  // ---------------- sequencer ----------------
  logic signed [ACC_W-1:0] sum_c, dsub_c, tlo_c, thi_c, qs_c, r2_c;
  logic signed [31:0]      d_c [3];
  logic signed [31:0]      dot_c;
  logic [CNT_W-1:0]        n_c;
  logic signed [UNIT_W-1:0] qun_c;
  logic [31:0]             vmag_c;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    in_nxt        = in_r;
    vec_nxt       = vec_r;
    un_nxt        = un_r;
    u_nxt         = u_r;
    duv_nxt       = duv_r;
    f_nxt         = f_r;
    l_nxt         = l_r;
    p_nxt         = p_r;
    w_nxt         = w_r;
    bp_nxt        = bp_r;
    k_nxt         = k_r;
    len_nxt       = len_r;
    tca_nxt       = tca_r;
    den_nxt       = den_r;
    num_nxt       = num_r;
    t_nxt         = t_r;
    bt_nxt        = bt_r;
    d2_nxt        = d2_r;
    acc_nxt       = acc_r;
    obj_i_nxt     = obj_i_r;
    n_nxt         = n_r;
    bi_nxt        = bi_r;
    found_nxt     = found_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ma            = '0;
    mb            = '0;
    mem_we        = 1'b0;
    mem_wdata     = '0;
    sq_start      = 1'b0;
    sq_in         = '0;
    dv_start      = 1'b0;
    dv_num        = '0;
    dv_den        = '0;

    sum_c  = acc_r + pfs;
    dsub_c = acc_r - pfs;
    r2_c   = pfs;
    tlo_c  = ACC_W'(tca_r) - ACC_W'(sq_rt_r[32:0]);
    thi_c  = ACC_W'(tca_r) + ACC_W'(sq_rt_r[32:0]);
    qs_c   = ACC_W'(dv_q_r);
    qun_c  = UNIT_W'(dv_q_r[UNIT_W-2:0]);
    vmag_c = mag32(vec_r[k_r]);
    dot_c  = sat32(sum_c);
    for (int j = 0; j < 3; j++) begin
      d_c[j] = '0;
    end
    d_c[0] = sat32(ACC_W'(in_r.pos_x) - ACC_W'(f_r[0]));
    d_c[1] = sat32(ACC_W'(in_r.pos_y) - ACC_W'(f_r[1]));
    d_c[2] = sat32(ACC_W'(in_r.pos_z) - ACC_W'(f_r[2]));
    n_c    = (CNT_W'(ocount_r) > N_MAX) ? N_MAX : CNT_W'(ocount_r);

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          in_nxt = in_word;
          if (in_word.mode == MODE_LOAD) begin
            vec_nxt[0] = in_word.norm_x;
            vec_nxt[1] = in_word.norm_y;
            vec_nxt[2] = in_word.norm_z;
            ret_nxt    = ST_LDWR;
          end else begin
            vec_nxt = cd_r;
            ret_nxt = ST_CU;
          end
          state_nxt = ST_UN0;
        end
      end

      // unit vector of vec_r into un_r
      ST_UN0: begin
        ma = 33'(vec_r[0]); mb = 33'(vec_r[0]);
        acc_nxt = '0;
        state_nxt = ST_UN1;
      end
      ST_UN1: begin
        ma = 33'(vec_r[1]); mb = 33'(vec_r[1]);
        acc_nxt = acc_r + ACC_W'(prod_r);
        state_nxt = ST_UN2;
      end
      ST_UN2: begin
        ma = 33'(vec_r[2]); mb = 33'(vec_r[2]);
        acc_nxt = acc_r + ACC_W'(prod_r);
        state_nxt = ST_UN3;
      end
      ST_UN3: begin
        sq_start = 1'b1;
        sq_in = 64'(acc_r + ACC_W'(prod_r));
        state_nxt = ST_UNS;
      end
      ST_UNS: begin
        if (sq_cnt_r == 6'd0) begin
          len_nxt = sq_rt_r[32:0];
          k_nxt = 2'd0;
          if (sq_rt_r == 64'd0) begin
            un_nxt[0] = '0; un_nxt[1] = '0; un_nxt[2] = '0;
            state_nxt = ret_r;
          end else begin
            state_nxt = ST_UND;
          end
        end
      end
      ST_UND: begin
        dv_start = 1'b1;
        dv_num = {vmag_c, 16'd0};
        dv_den = len_r;
        state_nxt = ST_UNW;
      end
      ST_UNW: begin
        if (dv_cnt_r == 6'd0) begin
          un_nxt[k_r] = vec_r[k_r][31] ? -qun_c : qun_c;
          if (k_r == 2'd2) begin
            state_nxt = ret_r;
          end else begin
            k_nxt = k_r + 2'd1;
            state_nxt = ST_UND;
          end
        end
      end

      // load: store the entry with its normalized plane normal
      ST_LDWR: begin
        mem_we        = (CNT_W'(in_r.slot) < N_MAX);
        mem_wdata.kind = in_r.kind;
        mem_wdata.cx  = in_r.pos_x;
        mem_wdata.cy  = in_r.pos_y;
        mem_wdata.cz  = in_r.pos_z;
        mem_wdata.rad = in_r.radius;
        mem_wdata.nx  = un_r[0];
        mem_wdata.ny  = un_r[1];
        mem_wdata.nz  = un_r[2];
        out_nxt       = '0;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      // cast: focal point F = C - u * focal
      ST_CU: begin
        u_nxt = un_r;
        state_nxt = ST_CF0;
      end
      ST_CF0: begin
        ma = 33'(u_r[0]); mb = $signed({2'b00, focal_r});
        state_nxt = ST_CF1;
      end
      ST_CF1: begin
        ma = 33'(u_r[1]); mb = $signed({2'b00, focal_r});
        f_nxt[0] = sat32(ACC_W'(cc_r[0]) - pfs);
        state_nxt = ST_CF2;
      end
      ST_CF2: begin
        ma = 33'(u_r[2]); mb = $signed({2'b00, focal_r});
        f_nxt[1] = sat32(ACC_W'(cc_r[1]) - pfs);
        state_nxt = ST_CF3;
      end
      ST_CF3: begin
        f_nxt[2] = sat32(ACC_W'(cc_r[2]) - pfs);
        state_nxt = ST_CD;
      end
      ST_CD: begin
        if (d_c[0] == 32'sd0 && d_c[1] == 32'sd0 && d_c[2] == 32'sd0) begin
          out_nxt       = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          vec_nxt   = d_c;
          ret_nxt   = ST_CDU;
          state_nxt = ST_UN0;
        end
      end
      ST_CDU: begin
        duv_nxt   = un_r;
        obj_i_nxt = '0;
        found_nxt = 1'b0;
        n_nxt     = n_c;
        if (n_c == '0) begin
          out_nxt       = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_OBJ0;
        end
      end

      // table read in flight
      ST_OBJ0: state_nxt = ST_OBJ1;
      ST_OBJ1: begin
        l_nxt[0] = sat32(ACC_W'(rd_q.cx) - ACC_W'(f_r[0]));
        l_nxt[1] = sat32(ACC_W'(rd_q.cy) - ACC_W'(f_r[1]));
        l_nxt[2] = sat32(ACC_W'(rd_q.cz) - ACC_W'(f_r[2]));
        state_nxt = (rd_q.kind == KIND_SPHERE) ? ST_S0 : ST_P0;
      end

      // sphere: tca, d^2, thc
      ST_S0: begin
        ma = 33'(l_r[0]); mb = 33'(duv_r[0]);
        acc_nxt = '0;
        state_nxt = ST_S1;
      end
      ST_S1: begin
        ma = 33'(l_r[1]); mb = 33'(duv_r[1]);
        acc_nxt = sum_c;
        state_nxt = ST_S2;
      end
      ST_S2: begin
        ma = 33'(l_r[2]); mb = 33'(duv_r[2]);
        acc_nxt = sum_c;
        state_nxt = ST_S3;
      end
      ST_S3: begin
        tca_nxt = dot_c;
        ma = 33'(l_r[0]); mb = 33'(l_r[0]);
        acc_nxt = '0;
        state_nxt = ST_S4;
      end
      ST_S4: begin
        ma = 33'(l_r[1]); mb = 33'(l_r[1]);
        acc_nxt = sum_c;
        state_nxt = ST_S5;
      end
      ST_S5: begin
        ma = 33'(l_r[2]); mb = 33'(l_r[2]);
        acc_nxt = sum_c;
        state_nxt = ST_S6;
      end
      ST_S6: begin
        ma = 33'(tca_r); mb = 33'(tca_r);
        acc_nxt = sum_c;
        state_nxt = ST_S7;
      end
      ST_S7: begin
        ma = $signed({2'b00, rd_q.rad}); mb = $signed({2'b00, rd_q.rad});
        d2_nxt = (dsub_c < 0) ? '0 : dsub_c;
        state_nxt = ST_S8;
      end
      ST_S8: begin
        if (d2_r > r2_c) begin
          state_nxt = ST_NEXT;
        end else begin
          sq_start = 1'b1;
          sq_in = 64'(r2_c - d2_r) << FRAC_BITS;
          state_nxt = ST_S9;
        end
      end
      ST_S9: begin
        if (sq_cnt_r == 6'd0) begin
          if (tlo_c > 0) begin
            t_nxt = sat32(tlo_c);
            state_nxt = ST_H0;
          end else if (thi_c > 0) begin
            t_nxt = sat32(thi_c);
            state_nxt = ST_H0;
          end else begin
            state_nxt = ST_NEXT;
          end
        end
      end

      // plane: den = duv.n, num = L.n, t = num / den
      ST_P0: begin
        ma = 33'(duv_r[0]); mb = 33'(rd_q.nx);
        acc_nxt = '0;
        state_nxt = ST_P1;
      end
      ST_P1: begin
        ma = 33'(duv_r[1]); mb = 33'(rd_q.ny);
        acc_nxt = sum_c;
        state_nxt = ST_P2;
      end
      ST_P2: begin
        ma = 33'(duv_r[2]); mb = 33'(rd_q.nz);
        acc_nxt = sum_c;
        state_nxt = ST_P3;
      end
      ST_P3: begin
        den_nxt = dot_c;
        ma = 33'(l_r[0]); mb = 33'(rd_q.nx);
        acc_nxt = '0;
        state_nxt = ST_P4;
      end
      ST_P4: begin
        ma = 33'(l_r[1]); mb = 33'(rd_q.ny);
        acc_nxt = sum_c;
        state_nxt = ST_P5;
      end
      ST_P5: begin
        ma = 33'(l_r[2]); mb = 33'(rd_q.nz);
        acc_nxt = sum_c;
        state_nxt = ST_P6;
      end
      ST_P6: begin
        num_nxt = dot_c;
        if (den_r == 32'sd0) begin
          state_nxt = ST_NEXT;
        end else begin
          dv_start = 1'b1;
          dv_num = {mag32(dot_c), 16'd0};
          dv_den = {1'b0, mag32(den_r)};
          state_nxt = ST_P7;
        end
      end
      ST_P7: begin
        if (dv_cnt_r == 6'd0) begin
          t_nxt = sat32((num_r[31] != den_r[31]) ? -qs_c : qs_c);
          state_nxt = ((num_r[31] != den_r[31]) && qs_c != 0) ? ST_NEXT : ST_H0;
        end
      end

      // hit point and in-front test
      ST_H0: begin
        ma = 33'(duv_r[0]); mb = 33'(t_r);
        state_nxt = ST_H1;
      end
      ST_H1: begin
        ma = 33'(duv_r[1]); mb = 33'(t_r);
        p_nxt[0] = sat32(ACC_W'(f_r[0]) + pfs);
        state_nxt = ST_H2;
      end
      ST_H2: begin
        ma = 33'(duv_r[2]); mb = 33'(t_r);
        p_nxt[1] = sat32(ACC_W'(f_r[1]) + pfs);
        state_nxt = ST_H3;
      end
      ST_H3: begin
        p_nxt[2] = sat32(ACC_W'(f_r[2]) + pfs);
        state_nxt = ST_H4;
      end
      ST_H4: begin
        for (int j = 0; j < 3; j++) begin
          w_nxt[j] = sat32(ACC_W'(p_r[j]) - ACC_W'(cc_r[j]));
        end
        state_nxt = ST_H5;
      end
      ST_H5: begin
        ma = 33'(w_r[0]); mb = 33'(u_r[0]);
        acc_nxt = '0;
        state_nxt = ST_H6;
      end
      ST_H6: begin
        ma = 33'(w_r[1]); mb = 33'(u_r[1]);
        acc_nxt = sum_c;
        state_nxt = ST_H7;
      end
      ST_H7: begin
        ma = 33'(w_r[2]); mb = 33'(u_r[2]);
        acc_nxt = sum_c;
        state_nxt = ST_H8;
      end
      ST_H8: begin
        // ties go to the later entry
        if (dot_c > 32'sd0 && (!found_r || t_r <= bt_r)) begin
          found_nxt = 1'b1;
          bt_nxt    = t_r;
          bi_nxt    = obj_i_r[OBJ_IDX_W-1:0];
          bp_nxt    = p_r;
        end
        state_nxt = ST_NEXT;
      end

      ST_NEXT: begin
        if (obj_i_r + CNT_W'(1) == n_r) begin
          out_nxt = '0;
          if (found_r) begin
            out_nxt.hit        = 1'b1;
            out_nxt.hit_object = 4'(bi_r);
            out_nxt.hit_x      = bp_r[0];
            out_nxt.hit_y      = bp_r[1];
            out_nxt.hit_z      = bp_r[2];
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          obj_i_nxt = obj_i_r + CNT_W'(1);
          state_nxt = ST_OBJ0;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      obj_i_r     <= '0;
      n_r         <= '0;
      k_r         <= '0;
      ret_r       <= ST_IDLE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      obj_i_r     <= obj_i_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      ret_r       <= ret_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    in_r    <= in_nxt;
    vec_r   <= vec_nxt;
    un_r    <= un_nxt;
    u_r     <= u_nxt;
    duv_r   <= duv_nxt;
    f_r     <= f_nxt;
    l_r     <= l_nxt;
    p_r     <= p_nxt;
    w_r     <= w_nxt;
    bp_r    <= bp_nxt;
    len_r   <= len_nxt;
    tca_r   <= tca_nxt;
    den_r   <= den_nxt;
    num_r   <= num_nxt;
    t_r     <= t_nxt;
    bt_r    <= bt_nxt;
    d2_r    <= d2_nxt;
    acc_r   <= acc_nxt;
    bi_r    <= bi_nxt;
    out_r   <= out_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_valid_r;
  assign out_word   = out_r;

  // ---------------- checks ----------------
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(sq_cnt_r != 6'd0 && dv_cnt_r != 6'd0))
    else $error("root and divider running together");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.hit) |-> (out_r.hit_object == 4'd0 &&
      out_r.hit_x == 32'sd0 && out_r.hit_y == 32'sd0 && out_r.hit_z == 32'sd0))
    else $error("miss result carries nonzero fields");

  a_obj_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OBJ1) |-> (obj_i_r < n_r))
    else $error("table walk past object count");

endmodule

[sim/ray_closest_hit_sphere_plane_unit_tb.sv]
// Self-checking testbench for the ray closest-hit unit: fixed-point predictor plus random loads, casts and noise.
`timescale 1ns / 100ps

module ray_closest_hit_sphere_plane_unit_tb;
  import rchs_pkg::*;

  localparam int QONE = 65536;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  rchs_in_t    in_word = '0;
  logic        out_strobe;
  rchs_out_t   out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_CAM_CX;
  logic [31:0] cfg_data = '0;

  ray_closest_hit_sphere_plane_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // -------- predictor state: camera config and object table --------
  longint      cam_c[3];
  longint      cam_d[3];
  longint      focal;
  int unsigned obj_cnt;
  bit          tbl_kind[MAX_OBJECTS];
  longint      tbl_cx[MAX_OBJECTS], tbl_cy[MAX_OBJECTS], tbl_cz[MAX_OBJECTS];
  longint      tbl_rad[MAX_OBJECTS];
  longint      tbl_nx[MAX_OBJECTS], tbl_ny[MAX_OBJECTS], tbl_nz[MAX_OBJECTS];

  rchs_in_t  pending_words[$];
  rchs_out_t expected_hits[$];
  int        mismatches = 0;
  int        gap_max = 4;
  bit        took = 1'b0;
  int        gap_left = 0;

  function automatic void queue_word(rchs_in_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q product scale-down, floor
  function automatic longint qshr(longint p);
    return p >>> FRAC_BITS;
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned absval(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint qdot(input longint a[3], input longint b[3]);
    return clamp32(qshr(a[0] * b[0]) + qshr(a[1] * b[1]) + qshr(a[2] * b[2]));
  endfunction

  function automatic void normalize3(input longint v[3], output longint u[3]);
    longint unsigned s, len, q;
    s = 0;
    for (int i = 0; i < 3; i++) s += absval(v[i]) * absval(v[i]);
    len = root64(s);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) u[i] = 0;
      else begin
        q = (absval(v[i]) << FRAC_BITS) / len;
        u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
  endfunction

  // Applies one accepted word to the table, or traces the ray and returns the nearest hit.
  function automatic rchs_out_t trace_nearest(rchs_in_t w);
    rchs_out_t r;
    longint u[3], f[3], d[3], duv[3], bp[3], c[3], l[3], p[3], wv[3], nv[3], nu[3];
    longint best_t, t, tca, rr, ll, d2, r2, thc, den, num;
    longint unsigned q;
    int n, best_i;
    bit found, skip;
    r = '0;
    best_t = 0;
    best_i = 0;
    found = 0;
    if (w.mode == MODE_LOAD) begin
      tbl_kind[w.slot] = w.kind;
      tbl_cx[w.slot] = longint'(w.pos_x);
      tbl_cy[w.slot] = longint'(w.pos_y);
      tbl_cz[w.slot] = longint'(w.pos_z);
      tbl_rad[w.slot] = longint'({1'b0, w.radius});
      tbl_nx[w.slot] = longint'(w.norm_x);
      tbl_ny[w.slot] = longint'(w.norm_y);
      tbl_nz[w.slot] = longint'(w.norm_z);
      return r;
    end
    normalize3(cam_d, u);
    d[0] = longint'(w.pos_x);
    d[1] = longint'(w.pos_y);
    d[2] = longint'(w.pos_z);
    for (int k = 0; k < 3; k++) begin
      f[k] = clamp32(cam_c[k] - qshr(u[k] * focal));
      d[k] = clamp32(d[k] - f[k]);
    end
    if (d[0] == 0 && d[1] == 0 && d[2] == 0) return r; // ray of zero length
    normalize3(d, duv);
    n = (obj_cnt < MAX_OBJECTS) ? obj_cnt : MAX_OBJECTS;
    for (int i = 0; i < n; i++) begin
      skip = 0;
      t = 0;
      c[0] = tbl_cx[i];
      c[1] = tbl_cy[i];
      c[2] = tbl_cz[i];
      for (int k = 0; k < 3; k++) l[k] = clamp32(c[k] - f[k]);
      if (tbl_kind[i] == KIND_SPHERE) begin
        tca = qdot(l, duv);
        rr = tbl_rad[i];
        ll = qshr(l[0] * l[0]) + qshr(l[1] * l[1]) + qshr(l[2] * l[2]);
        d2 = ll - qshr(tca * tca);
        r2 = qshr(rr * rr);
        if (d2 < 0) d2 = 0;
        if (d2 > r2) skip = 1;
        else begin
          thc = longint'(root64(longint'(r2 - d2) << FRAC_BITS));
          // nearer root first, far root when the near one is behind
          if (tca - thc > 0) t = tca - thc;
          else if (tca + thc > 0) t = tca + thc;
          else skip = 1;
          t = clamp32(t);
        end
      end else begin
        nv[0] = tbl_nx[i];
        nv[1] = tbl_ny[i];
        nv[2] = tbl_nz[i];
        normalize3(nv, nu);
        den = qdot(duv, nu);
        if (den == 0) skip = 1; // parallel ray or zero normal
        else begin
          num = qdot(l, nu);
          q = (absval(num) << FRAC_BITS) / absval(den);
          t = clamp32(((num < 0) != (den < 0)) ? -longint'(q) : longint'(q));
          if (t < 0) skip = 1;
        end
      end
      if (!skip) begin
        for (int k = 0; k < 3; k++) begin
          p[k] = clamp32(f[k] + qshr(duv[k] * t));
          wv[k] = clamp32(p[k] - cam_c[k]);
        end
        // must lie in front of the camera; ties go to the later object
        if (qdot(wv, u) > 0 && (!found || t <= best_t)) begin
          found = 1;
          best_t = t;
          best_i = i;
          bp = p;
        end
      end
    end
    if (found) begin
      r.hit = 1'b1;
      r.hit_object = best_i[3:0];
      r.hit_x = bp[0][31:0];
      r.hit_y = bp[1][31:0];
      r.hit_z = bp[2][31:0];
    end
    return r;
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      CFG_CAM_CX:  cam_c[0] = longint'(signed'(v));
      CFG_CAM_CY:  cam_c[1] = longint'(signed'(v));
      CFG_CAM_CZ:  cam_c[2] = longint'(signed'(v));
      CFG_CAM_DX:  cam_d[0] = longint'(signed'(v));
      CFG_CAM_DY:  cam_d[1] = longint'(signed'(v));
      CFG_CAM_DZ:  cam_d[2] = longint'(signed'(v));
      CFG_FOCAL:   focal = longint'({33'd0, v[30:0]});
      CFG_OBJ_CNT: obj_cnt = v[4:0];
      default: ;
    endcase
  endfunction

  // -------- monitor: accept words, predict, check results --------
  always @(posedge clk) begin
    rchs_out_t exp_w;
    bit        take_now;
    take_now = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if (start && !busy) begin
        expected_hits.insert(expected_hits.size(), trace_nearest(in_word));
        take_now = 1'b1;
      end
      if (out_strobe) begin
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", out_word);
        end else begin
          exp_w = expected_hits.pop_front();
          if (exp_w.hit !== out_word.hit || exp_w.hit_object !== out_word.hit_object ||
              exp_w.hit_x !== out_word.hit_x || exp_w.hit_y !== out_word.hit_y ||
              exp_w.hit_z !== out_word.hit_z) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected hit=%0d obj=%0d p=(%0d,%0d,%0d) ",
                        "got hit=%0d obj=%0d p=(%0d,%0d,%0d)"},
                       exp_w.hit, exp_w.hit_object, exp_w.hit_x, exp_w.hit_y, exp_w.hit_z,
                       out_word.hit, out_word.hit_object, out_word.hit_x, out_word.hit_y,
                       out_word.hit_z);
          end
        end
      end
    end
    took <= take_now;
  end

  // -------- driver: present queued words at the falling edge --------
  always @(negedge clk) begin
    bit nxt;
    nxt = start;
    if (!rst_n) nxt = 1'b0;
    else begin
      if (start && took) nxt = 1'b0;
      if (!nxt) begin
        if (gap_left > 0) gap_left--;
        else if (pending_words.size() > 0) begin
          in_word <= pending_words.pop_front();
          nxt = 1'b1;
          gap_left = $urandom_range(0, gap_max);
        end
      end
    end
    start <= nxt;
  end

  // -------- stimulus helpers --------
  function automatic int near_q(int span_units);
    int span;
    span = span_units * QONE;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic rchs_in_t load_word(int slot, bit kind, longint x, longint y, longint z,
                                         longint rad, longint nx, longint ny, longint nz);
    rchs_in_t w;
    w = '0;
    w.mode = MODE_LOAD;
    w.slot = slot[3:0];
    w.kind = kind;
    w.pos_x = x[31:0];
    w.pos_y = y[31:0];
    w.pos_z = z[31:0];
    w.radius = rad[30:0];
    w.norm_x = nx[31:0];
    w.norm_y = ny[31:0];
    w.norm_z = nz[31:0];
    return w;
  endfunction

  function automatic rchs_in_t cast_word(longint x, longint y, longint z);
    rchs_in_t w;
    w = '0;
    w.mode = ~MODE_LOAD;
    w.pos_x = x[31:0];
    w.pos_y = y[31:0];
    w.pos_z = z[31:0];
    w.slot = 4'($urandom());
    w.kind = 1'($urandom());
    w.radius = 31'($urandom());
    return w;
  endfunction

  function automatic rchs_in_t noise_word();
    rchs_in_t w;
    w.mode = 1'($urandom());
    w.slot = 4'($urandom());
    w.kind = 1'($urandom());
    w.pos_x = $urandom();
    w.pos_y = $urandom();
    w.pos_z = $urandom();
    w.radius = 31'($urandom());
    w.norm_x = $urandom();
    w.norm_y = $urandom();
    w.norm_z = $urandom();
    return w;
  endfunction

  // well-formed word: a modest scene object or a cast into it
  function automatic rchs_in_t scene_word();
    if ($urandom_range(0, 99) < 30)
      return load_word($urandom_range(0, 15), 1'($urandom()), near_q(16), near_q(16),
                       near_q(16), $urandom_range(QONE / 4, 6 * QONE),
                       near_q(2), near_q(2), near_q(2));
    return cast_word(near_q(12), near_q(12), near_q(12));
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_camera(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                              logic [31:0] fl, logic [31:0] cnt);
    write_reg(CFG_CAM_CX, cx);
    write_reg(CFG_CAM_CY, cy);
    write_reg(CFG_CAM_CZ, cz);
    write_reg(CFG_CAM_DX, dx);
    write_reg(CFG_CAM_DY, dy);
    write_reg(CFG_CAM_DZ, dz);
    write_reg(CFG_FOCAL, fl);
    write_reg(CFG_OBJ_CNT, cnt);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // block idle: nothing queued, nothing in flight
  task automatic drain();
    @(posedge clk);
    while (pending_words.size() != 0 || start || busy || expected_hits.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  initial begin
    int cnt, n_items;
    cam_c = '{0, 0, 0};
    cam_d = '{0, 0, QONE};
    focal = QONE;
    obj_cnt = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: fill the whole table, with extremes and a tied pair
    queue_word(load_word(0, KIND_SPHERE, 0, 0, 5 * QONE, QONE, 0, 0, 0));
    queue_word(load_word(1, KIND_SPHERE, 0, 0, 5 * QONE, QONE, 0, 0, 0));
    queue_word(load_word(2, ~KIND_SPHERE, 0, 0, 8 * QONE, 0, 0, 0, 0));
    queue_word(load_word(3, ~KIND_SPHERE, QONE, 0, 0, 0, QONE, 0, 0));
    queue_word(load_word(4, ~KIND_SPHERE, 0, 0, 9 * QONE, 0, 0, 0, -3 * QONE));
    queue_word(load_word(5, KIND_SPHERE, 32'h7fffffff, 32'h7fffffff,
                         32'h7fffffff, 31'h7fffffff, 32'h7fffffff,
                         32'h7fffffff, 32'h7fffffff));
    queue_word(load_word(6, ~KIND_SPHERE, 32'h80000000, 32'h80000000,
                         32'h80000000, 0, 32'h80000000, 32'h80000000,
                         32'h80000000));
    queue_word(load_word(7, KIND_SPHERE, 0, 0, 0, 0, 0, 0, 0));
    for (int s = 8; s < 16; s++) queue_word(scene_word());
    for (int s = 8; s < 16; s++)
      queue_word(load_word(s, s[0], near_q(10), near_q(10), near_q(10),
                           $urandom_range(QONE, 4 * QONE),
                           near_q(2), near_q(2), near_q(2)));
    drain();
    write_camera(0, 0, 0, 0, 0, QONE, QONE, 16);
    queue_word(cast_word(0, 0, -QONE));               // target at focal point
    queue_word(cast_word(0, 0, QONE));
    queue_word(cast_word(QONE, 0, QONE));
    queue_word(cast_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    queue_word(cast_word(32'h80000000, 32'h80000000, 32'h80000000));
    drain();
    write_camera(0, 0, 0, 0, 0, 0, QONE, 0);          // zero camera normal
    queue_word(cast_word(0, 0, QONE));
    drain();
    write_camera(0, 0, 0, 0, 0, 0, QONE, 16);
    queue_word(cast_word(0, 0, QONE));
    drain();

    // random phases; table stays fully written from here on
    for (int ph = 0; ph < 14; ph++) begin
      gap_max = (ph % 4 == 3) ? 0 : 4;
      n_items = 120;
      case (ph)
        0: begin
          cnt = 16;
          n_items = 30;
          write_camera(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                       32'h7fffffff, 32'h80000000, 32'h7fffffff, 31);
        end
        1: begin
          n_items = 40;
          write_camera($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), 16);
        end
        2: write_camera(0, 0, 0, 0, 0, 0, 0, 0);
        default: begin
          cnt = $urandom_range(1, 4);
          write_camera(near_q(2), near_q(2), near_q(2), near_q(2), near_q(2), near_q(2),
                       $urandom_range(QONE / 8, 3 * QONE), cnt);
        end
      endcase
      for (int j = 0; j < n_items; j++)
        queue_word(($urandom_range(0, 99) < 80) ? scene_word() : noise_word());
      drain();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("PASS ray_closest_hit_sphere_plane_unit");
    end else begin
      $display("FAIL ray_closest_hit_sphere_plane_unit");
    end
    $finish;
  end

  // watchdog
  initial begin
    #300000000;
    $display("FAIL ray_closest_hit_sphere_plane_unit");
    $finish;
  end

endmodule
